// ----- sv/nfc_reader_frame_checker_defines.svh -----
// Assertion macros for the frame checker
`ifndef NFC_READER_FRAME_CHECKER_DEFINES_SVH
`define NFC_READER_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

`define NFCFC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("frame checker assertion failed");

`define NFCFC_ASSERT_STEP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("frame checker step assertion failed");

`else

`define NFCFC_ASSERT(lbl, prop)

`define NFCFC_ASSERT_STEP(lbl, cond, prop)

`endif

`endif

// ----- sv/nfcfc_pkg.sv -----
package nfcfc_pkg;

	localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
	localparam logic [7:0] START_BYTE     = 8'hFF;
	localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;
	localparam logic [7:0] TFI_RESET      = 8'hD5;

	typedef enum logic [3:0] {
		PH_PRE0  = 4'd0,
		PH_PRE1  = 4'd1,
		PH_START = 4'd2,
		PH_LEN   = 4'd3,
		PH_LCS   = 4'd4,
		PH_TFI   = 4'd5,
		PH_DATA  = 4'd6,
		PH_DCS   = 4'd7,
		PH_POST  = 4'd8,
		PH_SKIP  = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		ST_PAYLOAD   = 3'd0,
		ST_OK        = 3'd1,
		ST_BAD_START = 3'd2,
		ST_BAD_LCS   = 3'd3,
		ST_SHORT     = 3'd4,
		ST_BAD_TFI   = 3'd5,
		ST_BAD_POST  = 3'd6,
		ST_ZERO_LEN  = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_end;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_payload;
		logic [2:0] status;
	} res_item_t;

	typedef struct packed {
		logic      emit;
		res_item_t item;
	} step_t;

endpackage

// ----- sv/nfcfc_in_reg.sv -----
module nfcfc_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	input  nfcfc_pkg::rx_item_t rx,
	input  logic                advance,
	output logic                rx_stall,
	output logic                valid_s1,
	output nfcfc_pkg::rx_item_t item_s1
);
	import nfcfc_pkg::*;

	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			item_s1 <= rx;
		end
	end

endmodule

// ----- sv/nfcfc_core.sv -----
`include "nfc_reader_frame_checker_defines.svh"

module nfcfc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                fire,
	input  nfcfc_pkg::rx_item_t item_s1,
	output nfcfc_pkg::step_t    step
);
	import nfcfc_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] frame_length_q, frame_length_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] frame_id_q;
	logic       verdict;
	logic [7:0] b;

	assign b = item_s1.rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q <= TFI_RESET;
		end else if (cfg_wr_en) begin
			frame_id_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_PRE0;
			frame_length_q <= 8'd0;
			bytes_left_q   <= 8'd0;
		end else if (fire) begin
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			bytes_left_q   <= bytes_left_d;
		end
	end

	always_comb begin
		phase_d                 = phase_q;
		frame_length_d          = frame_length_q;
		bytes_left_d            = bytes_left_q;
		verdict                 = 1'b0;
		step.emit               = 1'b0;
		step.item.payload_byte  = 8'd0;
		step.item.last_payload  = 1'b0;
		step.item.status        = ST_PAYLOAD;
		unique case (phase_q)
			PH_PRE0, PH_PRE1: begin
				if (b != PREAMBLE_BYTE) begin
					step.emit        = 1'b1;
					verdict          = 1'b1;
					step.item.status = ST_BAD_START;
				end else begin
					phase_d = (phase_q == PH_PRE0) ? PH_PRE1 : PH_START;
				end
			end
			PH_START: begin
				if (b != START_BYTE) begin
					step.emit        = 1'b1;
					verdict          = 1'b1;
					step.item.status = ST_BAD_START;
				end else begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				frame_length_d = b;
				phase_d        = PH_LCS;
			end
			PH_LCS: begin
				if (frame_length_q + b != 8'd0) begin
					step.emit        = 1'b1;
					verdict          = 1'b1;
					step.item.status = ST_BAD_LCS;
				end else if (frame_length_q == 8'd0) begin
					step.emit        = 1'b1;
					verdict          = 1'b1;
					step.item.status = ST_ZERO_LEN;
				end else begin
					phase_d = PH_TFI;
				end
			end
			PH_TFI: begin
				if (b != frame_id_q) begin
					step.emit        = 1'b1;
					verdict          = 1'b1;
					step.item.status = ST_BAD_TFI;
				end else begin
					bytes_left_d = frame_length_q - 8'd1;
					phase_d      = (frame_length_q != 8'd1) ? PH_DATA : PH_DCS;
				end
			end
			PH_DATA: begin
				step.emit              = 1'b1;
				step.item.payload_byte = b;
				step.item.last_payload = (bytes_left_q == 8'd1);
				bytes_left_d           = bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					phase_d = PH_DCS;
				end
			end
			PH_DCS: begin
				phase_d = PH_POST;
			end
			PH_POST: begin
				step.emit        = 1'b1;
				verdict          = 1'b1;
				step.item.status = (b == POSTAMBLE_BYTE) ? ST_OK : ST_BAD_POST;
			end
			default: begin
				verdict = 1'b1;
			end
		endcase

		if (item_s1.buffer_end && !verdict) begin
			step.emit              = 1'b1;
			step.item.status       = ST_SHORT;
			step.item.payload_byte = 8'd0;
			step.item.last_payload = 1'b0;
		end

		if (item_s1.buffer_end) begin
			phase_d = PH_PRE0;
		end else if (verdict) begin
			phase_d = PH_SKIP;
		end
	end

	`NFCFC_ASSERT(a_data_has_count, (phase_q == PH_DATA) |-> (bytes_left_q != 8'd0))
	`NFCFC_ASSERT(a_payload_only_in_data,
		(step.emit && step.item.status == ST_PAYLOAD) |-> (phase_q == PH_DATA))
	`NFCFC_ASSERT_STEP(a_end_rearms, fire && item_s1.buffer_end, phase_q == PH_PRE0)

endmodule

// ----- sv/nfc_reader_frame_checker.sv -----
// Channel   Direction  Payload     Handshake
// rx        in         rx_item_t   rx_valid / rx_stall
// res       out        res_item_t  res_valid / res_stall
// cfg       in         8-bit TFI   cfg_wr_en / cfg_wr_data
//
// One byte per cycle sustained while res_stall is not holding the pipeline; an accepted byte
// passes the input register, then the phase logic, and any result goes to the result register.
// Reset returns to waiting for the first preamble byte with identifier 0xD5.
// res_stall holds the result register and, once the input register is full, raises rx_stall.
`include "nfc_reader_frame_checker_defines.svh"

module nfc_reader_frame_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  nfcfc_pkg::rx_item_t  rx,
	output logic                 res_valid,
	input  logic                 res_stall,
	output nfcfc_pkg::res_item_t res,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data
);
	import nfcfc_pkg::*;

	logic     advance;
	logic     valid_s1;
	rx_item_t item_s1;
	step_t    step;
	logic     fire;

	assign advance = !res_valid || !res_stall;
	assign fire    = valid_s1 && advance;

	nfcfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx       (rx),
		.advance  (advance),
		.rx_stall (rx_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	nfcfc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.item_s1     (item_s1),
		.step        (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= fire && step.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step.emit) begin
			res <= step.item;
		end
	end

	`NFCFC_ASSERT(a_stall_backs_up, rx_stall |-> (res_valid && res_stall))
	`NFCFC_ASSERT(a_last_only_payload,
		(res_valid && res.status != ST_PAYLOAD) |-> (!res.last_payload && res.payload_byte == 8'd0))

endmodule
